[src/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the clock cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// bgc_pkg
// Types and constants of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int NUM_PADS = 4;
    localparam int IX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    localparam int HOLD_W = 17;
    localparam int SETUP_W = 13;
    localparam int COMBO_W = 12;
    localparam logic [SETUP_W-1:0] SETUP_MS = 13'd5000;
    localparam logic [COMBO_W-1:0] COMBO_MS = 12'd2000;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW = 2;
    localparam int Q_CW = 3;

    typedef enum logic [1:0] {
        EV_ACTION = 2'd0,
        EV_WAKE   = 2'd1,
        EV_SETUP  = 2'd2,
        EV_MOUSE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_AS_SHORT = 3'd0,
        REG_AS_LONG  = 3'd1,
        REG_CP_SHORT = 3'd2,
        REG_CP_LONG  = 3'd3,
        REG_HOLD_MS  = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WAKE,
        ST_ASSIST,
        ST_CAPTURE,
        ST_COMBO,
        ST_ALONG,
        ST_CLONG,
        ST_FLUSH
    } t_fstate;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  pad;
        logic [7:0]  code;
        logic        last;
    } t_event;

    typedef struct packed {
        logic        push;
        t_event      ev;
    } t_qpush;

    typedef struct packed {
        logic [7:0]  as_short;
        logic [7:0]  as_long;
        logic [7:0]  cp_short;
        logic [7:0]  cp_long;
        logic [15:0] hold_ms;
    } t_cfg;

    function automatic logic [1:0] pad_code(input logic [IX_W-1:0] ix);
        logic [31:0] wide;
        wide = 32'(ix);
        return wide[1:0];
    endfunction

endpackage

[src/button_gesture_classifier_top.sv]
// ----------------------------------------------------------------------------
// button_gesture_classifier_top
// Short and long press detector for the assistant and capture buttons.
// ----------------------------------------------------------------------------
// The input channel takes one item at a time: a controller report or a
// one-millisecond tick. o_ready is high only while no item is in work.
// After it is taken, a report passes through four report steps, three poll
// steps per controller and one closing step, and a tick through the poll
// and closing steps; o_ready returns in the cycle after the closing step, so
// an item is taken only once the last is through. Each check may find one
// event, which waits in a holding register until the next event is found or
// the closing step, and then enters a four-entry queue; the final event of an
// item, marked by o_last, enters in the closing step.
// The output channel shows the head of the queue; o_valid stays high with the
// event unchanged until it is taken. When the receiver stalls, the queue
// fills and the sequencer waits in place, so no event is lost.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data. The
// user must write it only while the block is idle, which is not enforced.
// Reset clears all controller state, empties the queue and loads the
// register defaults; the block takes items from the first cycle after it.
// ----------------------------------------------------------------------------
module button_gesture_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [1:0]  i_pad,
    input  logic        i_key_a,
    input  logic        i_key_assist,
    input  logic        i_key_capture,
    input  logic        i_key_home,
    input  logic        i_key_options,
    input  logic        i_key_menu,
    input  logic        i_host_suspended,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_kind,
    output logic [1:0]  o_event_pad,
    output logic [7:0]  o_action_code,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import bgc_pkg::*;

    t_cfg   r_cfg;
    t_qpush w_push;
    t_event w_ev;
    logic   w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.as_short <= '0;
            r_cfg.as_long  <= '0;
            r_cfg.cp_short <= '0;
            r_cfg.cp_long  <= '0;
            r_cfg.hold_ms  <= 16'd500;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_AS_SHORT: r_cfg.as_short <= i_cfg_data[7:0];
                REG_AS_LONG:  r_cfg.as_long  <= i_cfg_data[7:0];
                REG_CP_SHORT: r_cfg.cp_short <= i_cfg_data[7:0];
                REG_CP_LONG:  r_cfg.cp_long  <= i_cfg_data[7:0];
                REG_HOLD_MS:  r_cfg.hold_ms  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bgc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_pad            (i_pad),
        .i_key_a          (i_key_a),
        .i_key_assist     (i_key_assist),
        .i_key_capture    (i_key_capture),
        .i_key_home       (i_key_home),
        .i_key_options    (i_key_options),
        .i_key_menu       (i_key_menu),
        .i_host_suspended (i_host_suspended),
        .i_cfg            (r_cfg),
        .o_push           (w_push),
        .i_q_full         (w_full)
    );

    bgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ev    (w_ev)
    );

    assign o_event_kind  = w_ev.kind;
    assign o_event_pad   = w_ev.pad;
    assign o_action_code = w_ev.code;
    assign o_last        = w_ev.last;

endmodule

[src/bgc_front.sv]
// ----------------------------------------------------------------------------
// bgc_front
// Accepts items, updates the per-controller state and sequences the events.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_op,
    input  logic [1:0]      i_pad,
    input  logic            i_key_a,
    input  logic            i_key_assist,
    input  logic            i_key_capture,
    input  logic            i_key_home,
    input  logic            i_key_options,
    input  logic            i_key_menu,
    input  logic            i_host_suspended,
    input  bgc_pkg::t_cfg   i_cfg,
    output bgc_pkg::t_qpush o_push,
    input  logic            i_q_full
);
    import bgc_pkg::*;

    t_fstate r_state, n_state;

    logic [IX_W-1:0] r_pad, r_poll;
    logic r_ka, r_kas, r_kc, r_kh, r_ko, r_km, r_susp;

    logic               r_ah [NUM_PADS];
    logic               r_ad [NUM_PADS];
    logic [HOLD_W-1:0]  r_at [NUM_PADS];
    logic               r_ch [NUM_PADS];
    logic               r_cd [NUM_PADS];
    logic [HOLD_W-1:0]  r_ct [NUM_PADS];
    logic               r_sa [NUM_PADS];
    logic [SETUP_W-1:0] r_st [NUM_PADS];
    logic               r_ca [NUM_PADS];
    logic [COMBO_W-1:0] r_mt [NUM_PADS];
    logic               r_cf [NUM_PADS];

    logic n_ah, n_ad, n_ch, n_cd, n_sa, n_ca, n_cf;
    logic [HOLD_W-1:0]  n_at, n_ct;
    logic [SETUP_W-1:0] n_st;
    logic [COMBO_W-1:0] n_mt;

    t_event r_hold;
    logic   r_hold_vld;

    logic [IX_W-1:0] w_ix;
    logic [IX_W-1:0] w_pad_in;
    logic   w_emit, w_adv, w_wr, w_accept, w_poll_end, w_flush_push;
    t_event w_ev;
    logic [HOLD_W-1:0] w_long;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_long   = HOLD_W'(i_cfg.hold_ms);
    assign w_poll_end = (r_poll == IX_W'(NUM_PADS - 1));
    assign w_pad_in = (32'(i_pad) >= NUM_PADS) ? '0 : IX_W'(i_pad);
    assign w_ix = (r_state == ST_COMBO || r_state == ST_ALONG || r_state == ST_CLONG)
                  ? r_poll : r_pad;

    always_comb begin
        n_state = r_state;
        w_emit  = 1'b0;
        w_ev    = '0;
        w_ev.pad = pad_code(w_ix);
        n_ah = r_ah[w_ix];
        n_ad = r_ad[w_ix];
        n_at = r_at[w_ix];
        n_ch = r_ch[w_ix];
        n_cd = r_cd[w_ix];
        n_ct = r_ct[w_ix];
        n_sa = r_sa[w_ix];
        n_st = r_st[w_ix];
        n_ca = r_ca[w_ix];
        n_mt = r_mt[w_ix];
        n_cf = r_cf[w_ix];
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_op ? ST_COMBO : ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (r_kh && r_ko && r_km) begin
                    if (!n_sa) begin
                        n_sa = 1'b1;
                        n_st = '0;
                    end else if (n_st > SETUP_MS) begin
                        w_emit = 1'b1;
                        w_ev.kind = EV_SETUP;
                        n_st = '0;
                    end
                end else begin
                    n_sa = 1'b0;
                    n_st = '0;
                end
                n_state = ST_WAKE;
            end
            ST_WAKE: begin
                if (r_susp && (r_ka || r_kas || r_kc)) begin
                    w_emit = 1'b1;
                    w_ev.kind = EV_WAKE;
                end
                n_state = ST_ASSIST;
            end
            ST_ASSIST: begin
                if (r_kas && !n_ah) begin
                    n_ah = 1'b1;
                    n_ad = 1'b0;
                    n_at = '0;
                end else if (!r_kas && n_ah) begin
                    if (!n_ad) begin
                        w_emit = 1'b1;
                        w_ev.kind = EV_ACTION;
                        w_ev.code = i_cfg.as_short;
                    end
                    n_ah = 1'b0;
                    n_ad = 1'b0;
                end
                n_state = ST_CAPTURE;
            end
            ST_CAPTURE: begin
                if (r_kc && !n_ch) begin
                    n_ch = 1'b1;
                    n_cd = 1'b0;
                    n_ct = '0;
                end else if (!r_kc && n_ch) begin
                    if (!n_cd) begin
                        w_emit = 1'b1;
                        w_ev.kind = EV_ACTION;
                        w_ev.code = i_cfg.cp_short;
                    end
                    n_ch = 1'b0;
                    n_cd = 1'b0;
                end
                if (r_kas && r_kc) begin
                    if (!n_ca) begin
                        n_ca = 1'b1;
                        n_mt = '0;
                    end
                end else if (!r_kas && !r_kc) begin
                    n_ca = 1'b0;
                    n_mt = '0;
                    n_cf = 1'b0;
                end
                n_state = ST_COMBO;
            end
            ST_COMBO: begin
                if (n_ca && !n_cf) begin
                    if (n_mt > COMBO_MS) begin
                        n_cf = 1'b1;
                        w_emit = 1'b1;
                        w_ev.kind = EV_MOUSE;
                    end else begin
                        n_ad = 1'b1;
                        n_cd = 1'b1;
                    end
                end
                n_state = ST_ALONG;
            end
            ST_ALONG: begin
                if (n_ah && !n_ad && n_at >= w_long) begin
                    n_ad = 1'b1;
                    w_emit = 1'b1;
                    w_ev.kind = EV_ACTION;
                    w_ev.code = i_cfg.as_long;
                end
                n_state = ST_CLONG;
            end
            ST_CLONG: begin
                if (n_ch && !n_cd && n_ct >= w_long) begin
                    n_cd = 1'b1;
                    w_emit = 1'b1;
                    w_ev.kind = EV_ACTION;
                    w_ev.code = i_cfg.cp_long;
                end
                n_state = w_poll_end ? ST_FLUSH : ST_COMBO;
            end
            ST_FLUSH: begin
                if (!r_hold_vld || !i_q_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        w_adv = !(w_emit && r_hold_vld && i_q_full);
        if (!w_adv) begin
            n_state = r_state;
        end
    end

    assign w_wr = w_adv && (r_state != ST_IDLE) && (r_state != ST_FLUSH);
    assign w_flush_push = (r_state == ST_FLUSH) && r_hold_vld && !i_q_full;

    always_comb begin
        o_push.push = (w_emit && r_hold_vld && w_adv) || w_flush_push;
        o_push.ev = r_hold;
        o_push.ev.last = (r_state == ST_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_poll <= '0;
        end else begin
            if (w_emit && w_adv) begin
                r_hold_vld <= 1'b1;
            end else if (w_flush_push) begin
                r_hold_vld <= 1'b0;
            end
            if (w_accept) begin
                r_poll <= '0;
            end else if (r_state == ST_CLONG && w_adv && !w_poll_end) begin
                r_poll <= r_poll + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && w_adv) begin
            r_hold <= w_ev;
        end
        if (w_accept) begin
            r_pad  <= w_pad_in;
            r_ka   <= i_key_a;
            r_kas  <= i_key_assist;
            r_kc   <= i_key_capture;
            r_kh   <= i_key_home;
            r_ko   <= i_key_options;
            r_km   <= i_key_menu;
            r_susp <= i_host_suspended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PADS; i++) begin
                r_ah[i] <= 1'b0;
                r_ad[i] <= 1'b0;
                r_at[i] <= '0;
                r_ch[i] <= 1'b0;
                r_cd[i] <= 1'b0;
                r_ct[i] <= '0;
                r_sa[i] <= 1'b0;
                r_st[i] <= '0;
                r_ca[i] <= 1'b0;
                r_mt[i] <= '0;
                r_cf[i] <= 1'b0;
            end
        end else if (w_accept && i_op) begin
            for (int i = 0; i < NUM_PADS; i++) begin
                if (r_ah[i] && !(&r_at[i])) begin
                    r_at[i] <= r_at[i] + 1'b1;
                end
                if (r_ch[i] && !(&r_ct[i])) begin
                    r_ct[i] <= r_ct[i] + 1'b1;
                end
                if (r_sa[i] && !(&r_st[i])) begin
                    r_st[i] <= r_st[i] + 1'b1;
                end
                if (r_ca[i] && !(&r_mt[i])) begin
                    r_mt[i] <= r_mt[i] + 1'b1;
                end
            end
        end else if (w_wr) begin
            r_ah[w_ix] <= n_ah;
            r_ad[w_ix] <= n_ad;
            r_at[w_ix] <= n_at;
            r_ch[w_ix] <= n_ch;
            r_cd[w_ix] <= n_cd;
            r_ct[w_ix] <= n_ct;
            r_sa[w_ix] <= n_sa;
            r_st[w_ix] <= n_st;
            r_ca[w_ix] <= n_ca;
            r_mt[w_ix] <= n_mt;
            r_cf[w_ix] <= n_cf;
        end
    end

    `ASSERT_NEXT(a_flush_done, i_clk, i_rst_n, r_state == ST_FLUSH && !r_hold_vld, r_state == ST_IDLE, "flush did not return to idle")
    `ASSERT_ALWAYS(a_poll_range, i_clk, i_rst_n, 32'(r_poll) < NUM_PADS, "poll index out of range")
    `ASSERT_NEXT(a_tick_poll, i_clk, i_rst_n, w_accept && i_op, r_state == ST_COMBO && r_poll == '0, "tick did not start the poll")

endmodule

[src/bgc_queue.sv]
// ----------------------------------------------------------------------------
// bgc_queue
// Event queue between the sequencer and the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bgc_pkg::t_qpush i_push,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_ready,
    output bgc_pkg::t_event o_ev
);
    import bgc_pkg::*;

    t_event          r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            w_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ev    = r_mem[r_rp];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push.push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push.push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wp] <= i_push.ev;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push.push && o_full), "push into a full queue")
    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, 32'(r_cnt) <= Q_DEPTH, "queue count out of range")
    `ASSERT_NEXT(a_pop_cnt, i_clk, i_rst_n, w_pop && !i_push.push, r_cnt == $past(r_cnt) - 1'b1, "pop did not shrink the queue")

endmodule
